// ===== hw/rtl/mono_last_note_priority_stack_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the note stack
// Implication and next-cycle implication forms, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef MONO_LAST_NOTE_PRIORITY_STACK_ASSERT_SVH
`define MONO_LAST_NOTE_PRIORITY_STACK_ASSERT_SVH

// same-cycle implication
`define MLNPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mlnps: same-cycle check failed");

// next-cycle implication
`define MLNPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mlnps: next-cycle check failed");

`endif

// ===== hw/rtl/mlnps_pkg.sv =====
// ----------------------------------------------------------------------------
// mlnps_pkg
// Types and constants of the last-note-priority note stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlnps_pkg;

    localparam int NOTE_W    = 7;
    localparam int LEVEL_W   = 7;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 5;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;

    typedef struct packed {
        logic [NOTE_W-1:0]  note;
        logic [LEVEL_W-1:0] level;
    } entry_t;

endpackage

// ===== hw/rtl/mono_last_note_priority_stack.sv =====
// ----------------------------------------------------------------------------
// mono_last_note_priority_stack
// Monophonic last-note-priority stack of held notes and velocities.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tuser opcode, s_tdata note, velocity
//  m_      | out       | m_tvalid/m_tready  | m_tdata one status word per request
//
//  A note-on or note-off request passes the scan, shift and finish steps, then a
//  result step on a legato return, then the output step: the scan reads one entry
//  per cycle until a match or the last held entry, the shift moves one entry per
//  cycle, both through the stack memory. All-notes-off goes straight to output.
//  Reset (synchronous, aresetn low) empties the stack; no clearing pass.
//  A finished result waits in the output register; the next request is
//  taken while it waits and stalls only at its own output step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_last_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // note[6:0], velocity[13:7], zero[15:14]
    input  logic [mlnps_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [mlnps_pkg::OP_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // current_note[6:0], current_valid[7], current_level[14:8], prior_note[21:15],
    // prior_valid[22], glide[23], triggered[24], released[25], held_count[30:26],
    // zero[31]
    output logic [mlnps_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import mlnps_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_MAX = CW'(STACK_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(STACK_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_RES   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [OP_W-1:0]    op_reg;
    logic [NOTE_W-1:0]  note_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [CW-1:0]      depth_reg;
    logic               snd_valid_reg;
    logic [NOTE_W-1:0]  snd_note_reg;
    logic [LEVEL_W-1:0] snd_level_reg;
    logic               pri_valid_reg;
    logic [NOTE_W-1:0]  pri_note_reg;
    logic               glide_reg;
    logic               trig_reg;
    logic               rel_reg;
    logic [CW-1:0]      scan_idx_reg;
    logic               pend_reg;
    logic [AW-1:0]      pend_idx_reg;
    logic [AW-1:0]      sh_idx_reg;
    logic [AW-1:0]      top_reg;
    logic               wpend_reg;
    logic [AW-1:0]      wpend_idx_reg;
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    entry_t             mem [STACK_DEPTH];
    entry_t             rd_data_reg;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    entry_t             mem_wdata;

    logic               accept;
    logic               hit;
    logic               scan_end;
    logic               shift_more;
    logic               sound_hit;
    logic               out_free;
    logic [CW-1:0]      depth_m1;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign hit        = pend_reg && (rd_data_reg.note == note_reg);
    assign scan_end   = (scan_idx_reg == depth_reg);
    assign shift_more = (sh_idx_reg < top_reg);
    assign sound_hit  = snd_valid_reg && (snd_note_reg == note_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign depth_m1   = depth_reg - CW'(1);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            ST_SCAN: begin
                if (!hit && !scan_end) begin
                    mem_re    = 1'b1;
                    mem_raddr = scan_idx_reg[AW-1:0];
                end
            end
            ST_SHIFT: begin
                mem_we    = wpend_reg;
                mem_waddr = wpend_idx_reg;
                if (shift_more) begin
                    mem_re    = 1'b1;
                    mem_raddr = sh_idx_reg + AW'(1);
                end
            end
            ST_FIN: begin
                if (op_reg == OP_NOTE_ON) begin
                    mem_we          = 1'b1;
                    mem_waddr       = top_reg;
                    mem_wdata.note  = note_reg;
                    mem_wdata.level = level_reg;
                end else if (sound_hit && depth_reg != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = depth_m1[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_NOTE_ON || s_tuser == OP_NOTE_OFF) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (hit || scan_end) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!shift_more) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (op_reg != OP_NOTE_ON && sound_hit && depth_reg != '0) begin
                    state_next = ST_RES;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RES: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // request payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_tuser;
            note_reg  <= s_tdata[NOTE_W-1:0];
            level_reg <= s_tdata[NOTE_W+LEVEL_W-1:NOTE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            snd_valid_reg <= 1'b0;
            snd_note_reg  <= '0;
            snd_level_reg <= '0;
            pri_valid_reg <= 1'b0;
            pri_note_reg  <= '0;
            glide_reg     <= 1'b0;
            trig_reg      <= 1'b0;
            rel_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            sh_idx_reg    <= '0;
            top_reg       <= '0;
            wpend_reg     <= 1'b0;
            wpend_idx_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        scan_idx_reg <= '0;
                        pend_reg     <= 1'b0;
                        trig_reg     <= (s_tuser == OP_NOTE_ON);
                        rel_reg      <= 1'b0;
                        case (s_tuser)
                            OP_NOTE_ON: begin
                                pri_valid_reg <= snd_valid_reg;
                                pri_note_reg  <= snd_note_reg;
                                glide_reg     <= snd_valid_reg;
                                snd_valid_reg <= 1'b1;
                                snd_note_reg  <= s_tdata[NOTE_W-1:0];
                                snd_level_reg <= s_tdata[NOTE_W+LEVEL_W-1:NOTE_W];
                            end
                            OP_ALL_OFF: begin
                                depth_reg     <= '0;
                                snd_valid_reg <= 1'b0;
                                snd_note_reg  <= '0;
                                snd_level_reg <= '0;
                                pri_valid_reg <= 1'b0;
                                pri_note_reg  <= '0;
                                glide_reg     <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (hit || scan_end) begin
                        wpend_reg <= 1'b0;
                        if (op_reg == OP_NOTE_ON) begin
                            if (hit) begin
                                sh_idx_reg <= pend_idx_reg;
                                top_reg    <= depth_m1[AW-1:0];
                            end else if (depth_reg < DEPTH_MAX) begin
                                sh_idx_reg <= depth_reg[AW-1:0];
                                top_reg    <= depth_reg[AW-1:0];
                                depth_reg  <= depth_reg + CW'(1);
                            end else begin
                                // full: drop the oldest entry
                                sh_idx_reg <= '0;
                                top_reg    <= LAST_IDX;
                            end
                        end else if (hit) begin
                            sh_idx_reg <= pend_idx_reg;
                            top_reg    <= depth_m1[AW-1:0];
                            depth_reg  <= depth_m1;
                        end else begin
                            sh_idx_reg <= '0;
                            top_reg    <= '0;
                        end
                    end else begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= scan_idx_reg[AW-1:0];
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                    end
                end
                ST_SHIFT: begin
                    if (shift_more) begin
                        wpend_reg     <= 1'b1;
                        wpend_idx_reg <= sh_idx_reg;
                        sh_idx_reg    <= sh_idx_reg + AW'(1);
                    end else begin
                        wpend_reg <= 1'b0;
                    end
                end
                ST_FIN: begin
                    if (op_reg != OP_NOTE_ON && sound_hit) begin
                        pri_valid_reg <= 1'b1;
                        pri_note_reg  <= snd_note_reg;
                        if (depth_reg == '0) begin
                            snd_valid_reg <= 1'b0;
                            snd_note_reg  <= '0;
                            snd_level_reg <= '0;
                            glide_reg     <= 1'b0;
                            rel_reg       <= 1'b1;
                        end
                    end
                end
                ST_RES: begin
                    // legato return to the new top of stack
                    snd_note_reg  <= rd_data_reg.note;
                    snd_level_reg <= rd_data_reg.level;
                    glide_reg     <= 1'b1;
                    trig_reg      <= 1'b1;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, COUNT_W'(depth_reg), rel_reg, trig_reg,
                                         glide_reg, pri_valid_reg, pri_note_reg,
                                         snd_level_reg, snd_valid_reg, snd_note_reg};
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/mlnps_checker.sv =====
// ----------------------------------------------------------------------------
// mlnps_checker
// Port-level checks on the result stream of the note stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mono_last_note_priority_stack_assert.svh"

module mlnps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // silent result reads as note and level zero
    `MLNPS_ASSERT_IMP(a_silent_zero, aclk, aresetn, m_tvalid && !m_tdata[7], m_tdata[6:0] == 7'd0 && m_tdata[14:8] == 7'd0)
    // trigger only with a sounding note, never together with release
    `MLNPS_ASSERT_IMP(a_trig_sounds, aclk, aresetn, m_tvalid && m_tdata[24], m_tdata[7] && !m_tdata[25])
    // release leaves an empty stack and a valid prior note
    `MLNPS_ASSERT_IMP(a_rel_empty, aclk, aresetn, m_tvalid && m_tdata[25], !m_tdata[7] && m_tdata[22] && m_tdata[30:26] == 5'd0)
    // stalled result holds
    `MLNPS_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind mono_last_note_priority_stack mlnps_checker u_mlnps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
